// ===== rtl/rmpsc_pkg.sv =====
// Shared types, register addresses and constants of the PWM slew controller
package rmpsc_pkg;

	localparam int NumServo = 2;
	localparam int NumLed   = 3;
	localparam int NumChan  = NumServo + NumLed;

	localparam logic OpWrite = 1'b0;
	localparam logic OpTick  = 1'b1;

	localparam logic [7:0] AddrRate    = 8'h01;
	localparam logic [7:0] AddrClaw    = 8'h10;
	localparam logic [7:0] AddrTorpedo = 8'h11;
	localparam logic [7:0] AddrRed     = 8'h50;
	localparam logic [7:0] AddrGreen   = 8'h51;
	localparam logic [7:0] AddrBlue    = 8'h52;

	localparam logic [7:0]        DefaultRate = 8'd250;
	localparam logic [7:0]        ServoCenter = 8'd100;
	localparam logic [7:0]        ServoOffset = 8'd100;
	localparam logic signed [7:0] ServoMin    = -8'sd100;
	localparam logic signed [7:0] ServoMax    = 8'sd100;

	localparam logic [15:0] ServoBase  = 16'd3600;
	localparam logic [15:0] ServoScale = 16'd13;
	localparam logic [15:0] LedScale   = 16'd254;

	typedef logic [15:0] level_t;
	typedef level_t [NumChan-1:0] level_vec_t;

	typedef struct packed {
		logic write_rejected;
		logic step_done;
	} flags_t;

	typedef struct packed {
		logic       step;
		level_vec_t target;
	} slew_ctl_t;

endpackage

// ===== rtl/rmpsc_cmd_if.sv =====
// Input channel: bus writes and microsecond ticks
interface rmpsc_cmd_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic [7:0] reg_address;
	logic [7:0] write_value;

	modport source(output valid, opcode, reg_address, write_value, input ready);
	modport sink(input valid, opcode, reg_address, write_value, output ready);
endinterface

// ===== rtl/rmpsc_rsp_if.sv =====
// Result channel: drive levels and status flags
interface rmpsc_rsp_if;
	logic        valid;
	logic        ready;
	logic [15:0] claw_level;
	logic [15:0] torpedo_level;
	logic [15:0] red_level;
	logic [15:0] green_level;
	logic [15:0] blue_level;
	logic        write_rejected;
	logic        step_done;

	modport source(output valid, claw_level, torpedo_level, red_level, green_level,
		blue_level, write_rejected, step_done, input ready);
	modport sink(input valid, claw_level, torpedo_level, red_level, green_level,
		blue_level, write_rejected, step_done, output ready);
endinterface

// ===== rtl/rmpsc_regs.sv =====
// Register file, tick divider and target computation
module rmpsc_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  opcode,
	input  logic [7:0]            reg_address,
	input  logic [7:0]            write_value,
	output rmpsc_pkg::slew_ctl_t  ctl,
	output rmpsc_pkg::flags_t     flags
);

	logic [7:0] tick_rate_q;
	logic [7:0] servo_q [rmpsc_pkg::NumServo];
	logic [7:0] led_q   [rmpsc_pkg::NumLed];
	logic [9:0] tick_count_q;

	logic       is_write;
	logic       is_tick;
	logic       rate_wr;
	logic       servo_sel;
	logic       in_range;
	logic [9:0] period;
	logic [9:0] count_next;
	logic       hit;

	always_comb begin
		is_write   = (opcode == rmpsc_pkg::OpWrite);
		is_tick    = (opcode == rmpsc_pkg::OpTick);
		rate_wr    = is_write && (reg_address == rmpsc_pkg::AddrRate);
		servo_sel  = is_write && ((reg_address == rmpsc_pkg::AddrClaw) ||
			(reg_address == rmpsc_pkg::AddrTorpedo));
		in_range   = ($signed(write_value) >= rmpsc_pkg::ServoMin) &&
			($signed(write_value) <= rmpsc_pkg::ServoMax);
		period     = {tick_rate_q, 2'b00};
		count_next = tick_count_q + 10'd1;
		hit        = (tick_rate_q == 8'd0) || (count_next >= period);

		flags.write_rejected = servo_sel && !in_range;
		flags.step_done      = is_tick && hit;
		ctl.step             = is_tick && hit;
		for (int i = 0; i < rmpsc_pkg::NumServo; i++) begin
			ctl.target[i] = rmpsc_pkg::ServoBase +
				rmpsc_pkg::ServoScale * rmpsc_pkg::level_t'(servo_q[i]);
		end
		for (int i = 0; i < rmpsc_pkg::NumLed; i++) begin
			ctl.target[rmpsc_pkg::NumServo + i] =
				rmpsc_pkg::LedScale * rmpsc_pkg::level_t'(led_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q  <= rmpsc_pkg::DefaultRate;
			tick_count_q <= 10'd0;
			for (int i = 0; i < rmpsc_pkg::NumServo; i++) servo_q[i] <= rmpsc_pkg::ServoCenter;
			for (int i = 0; i < rmpsc_pkg::NumLed; i++) led_q[i] <= 8'd0;
		end else if (en) begin
			if (rate_wr) begin
				tick_rate_q  <= write_value;
				tick_count_q <= 10'd0;
			end
			if (is_tick) begin
				tick_count_q <= hit ? 10'd0 : count_next;
			end
			if (servo_sel && in_range) begin
				servo_q[reg_address[0]] <= write_value + rmpsc_pkg::ServoOffset;
			end
			for (int i = 0; i < rmpsc_pkg::NumLed; i++) begin
				if (is_write && (reg_address == rmpsc_pkg::AddrRed + 8'(i))) begin
					led_q[i] <= write_value;
				end
			end
		end
	end

endmodule

// ===== rtl/rmpsc_slew.sv =====
// Drive level registers, stepped by one toward their targets
module rmpsc_slew (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  rmpsc_pkg::slew_ctl_t  ctl,
	output rmpsc_pkg::level_vec_t level_next
);

	rmpsc_pkg::level_vec_t level_q;

	always_comb begin
		for (int i = 0; i < rmpsc_pkg::NumChan; i++) begin
			level_next[i] = level_q[i];
			if (ctl.step) begin
				if (ctl.target[i] > level_q[i]) begin
					level_next[i] = level_q[i] + 16'd1;
				end else if (ctl.target[i] < level_q[i]) begin
					level_next[i] = level_q[i] - 16'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (en) begin
			level_q <= level_next;
		end
	end

endmodule

// ===== rtl/register_mapped_pwm_slew_controller.sv =====
// Top level of the register-mapped PWM slew controller
//
//  channel  dir  word
//  cmd      in   opcode, reg_address, write_value
//  rsp      out  five drive levels, write_rejected, step_done
//
// One word is taken per cycle while cmd.ready is high; its result sits in the output register in the next cycle.
// Each word takes a single update pass into the result register.
// A new word is taken while a result waits, so long as rsp is ready or empty.
// Reset restores default rate, centred servos, dark LEDs and zero levels.
module register_mapped_pwm_slew_controller (
	input logic        clk,
	input logic        arst_n,
	rmpsc_cmd_if.sink   cmd,
	rmpsc_rsp_if.source rsp
);

	logic                  accept;
	rmpsc_pkg::slew_ctl_t  ctl;
	rmpsc_pkg::flags_t     flags;
	rmpsc_pkg::level_vec_t level_next;

	logic                  rsp_valid_q;
	rmpsc_pkg::level_vec_t level_out_q;
	rmpsc_pkg::flags_t     flags_q;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	rmpsc_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (accept),
		.opcode      (cmd.opcode),
		.reg_address (cmd.reg_address),
		.write_value (cmd.write_value),
		.ctl         (ctl),
		.flags       (flags)
	);

	rmpsc_slew u_slew (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (accept),
		.ctl        (ctl),
		.level_next (level_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			level_out_q <= level_next;
			flags_q     <= flags;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.claw_level     = level_out_q[0];
	assign rsp.torpedo_level  = level_out_q[1];
	assign rsp.red_level      = level_out_q[2];
	assign rsp.green_level    = level_out_q[3];
	assign rsp.blue_level     = level_out_q[4];
	assign rsp.write_rejected = flags_q.write_rejected;
	assign rsp.step_done      = flags_q.step_done;

endmodule

// ===== sim/register_mapped_pwm_slew_controller_tb.sv =====
// Testbench: directed and random writes and ticks into the PWM slew controller, checked by a predictor
module register_mapped_pwm_slew_controller_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		rmpsc_pkg::level_vec_t level;
		rmpsc_pkg::flags_t     flags;
	} level_report_t;

	typedef enum int unsigned {
		ReadyAlways,
		ReadyRandom,
		ReadyPeriodic
	} ready_mode_t;

	class slew_scoreboard;
		logic [7:0]            rate;
		logic [7:0]            servo_set [rmpsc_pkg::NumServo];
		logic [7:0]            led_set [rmpsc_pkg::NumLed];
		rmpsc_pkg::level_vec_t level;
		logic [9:0]            tick_cnt;
		level_report_t         pending_reports[$];
		string                 chan_name [rmpsc_pkg::NumChan];
		int unsigned           errors;

		function new();
			rate      = rmpsc_pkg::DefaultRate;
			servo_set = '{default: rmpsc_pkg::ServoCenter};
			led_set   = '{default: 8'd0};
			level     = '0;
			tick_cnt  = '0;
			errors    = 0;
			chan_name = '{"claw_level", "torpedo_level", "red_level", "green_level",
				"blue_level"};
		endfunction

		function int unsigned reports_due();
			return pending_reports.size();
		endfunction

		function void note_word(logic op, logic [7:0] addr, logic [7:0] val);
			level_report_t     rep;
			logic signed [7:0] sval;
			logic [9:0]        period;
			logic [9:0]        next_cnt;
			int unsigned       target;
			rep.flags = '0;
			sval = val;
			if (op == rmpsc_pkg::OpWrite) begin
				if (addr == rmpsc_pkg::AddrRate) begin
					rate     = val;
					tick_cnt = '0;
				end else if (addr == rmpsc_pkg::AddrClaw || addr == rmpsc_pkg::AddrTorpedo) begin
					if (sval < rmpsc_pkg::ServoMin || sval > rmpsc_pkg::ServoMax) begin
						rep.flags.write_rejected = 1'b1;
					end else begin
						servo_set[addr[0]] = val + rmpsc_pkg::ServoOffset;
					end
				end else if (addr >= rmpsc_pkg::AddrRed && addr <= rmpsc_pkg::AddrBlue) begin
					led_set[2'(addr - rmpsc_pkg::AddrRed)] = val;
				end
			end else begin
				period   = {rate, 2'b00};
				next_cnt = tick_cnt + 10'd1;
				if (period == 10'd0 || next_cnt >= period) begin
					tick_cnt = '0;
					rep.flags.step_done = 1'b1;
					for (int ch = 0; ch < rmpsc_pkg::NumChan; ch++) begin
						if (ch < rmpsc_pkg::NumServo) begin
							target = 32'(rmpsc_pkg::ServoScale) * 32'(servo_set[ch]) +
								32'(rmpsc_pkg::ServoBase);
						end else begin
							target = 32'(rmpsc_pkg::LedScale) *
								32'(led_set[ch - rmpsc_pkg::NumServo]);
						end
						if (target > 32'(level[ch])) begin
							level[ch] = level[ch] + 16'd1;
						end else if (target < 32'(level[ch])) begin
							level[ch] = level[ch] - 16'd1;
						end
					end
				end else begin
					tick_cnt = next_cnt;
				end
			end
			rep.level = level;
			pending_reports.push_back(rep);
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("%0t ns: mismatch: %s", $realtime, msg);
		endtask

		task check_report(rmpsc_pkg::level_vec_t got_level, rmpsc_pkg::flags_t got_flags);
			level_report_t exp_rep;
			if (pending_reports.size() == 0) begin
				report_mismatch("result word with no input word pending");
				return;
			end
			exp_rep = pending_reports.pop_front();
			for (int ch = 0; ch < rmpsc_pkg::NumChan; ch++) begin
				if (got_level[ch] !== exp_rep.level[ch]) begin
					report_mismatch($sformatf("%s got %0d expected %0d", chan_name[ch],
						got_level[ch], exp_rep.level[ch]));
				end
			end
			if (got_flags.write_rejected !== exp_rep.flags.write_rejected) begin
				report_mismatch($sformatf("write_rejected got %b expected %b",
					got_flags.write_rejected, exp_rep.flags.write_rejected));
			end
			if (got_flags.step_done !== exp_rep.flags.step_done) begin
				report_mismatch($sformatf("step_done got %b expected %b",
					got_flags.step_done, exp_rep.flags.step_done));
			end
		endtask
	endclass

	logic           clk = 1'b0;
	logic           arst_n;
	slew_scoreboard sb;
	int unsigned    burst_left = 0;
	int unsigned    ready_phase_left = 0;
	ready_mode_t    ready_mode = ReadyAlways;

	rmpsc_cmd_if cmd_if();
	rmpsc_rsp_if rsp_if();

	register_mapped_pwm_slew_controller u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.rsp    (rsp_if)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		if (ready_phase_left == 0) begin
			ready_mode       = ready_mode_t'($urandom_range(0, 2));
			ready_phase_left = $urandom_range(20, 120);
		end
		ready_phase_left--;
		case (ready_mode)
			ReadyAlways: begin
				rsp_if.ready <= 1'b1;
			end
			ReadyRandom: begin
				rsp_if.ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				rsp_if.ready <= ((ready_phase_left % 7) > 2);
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_if.valid && cmd_if.ready) begin
				sb.note_word(cmd_if.opcode, cmd_if.reg_address, cmd_if.write_value);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				sb.check_report({rsp_if.blue_level, rsp_if.green_level, rsp_if.red_level,
					rsp_if.torpedo_level, rsp_if.claw_level},
					{rsp_if.write_rejected, rsp_if.step_done});
			end
		end
	end

	task automatic send_word(input logic op, input logic [7:0] addr, input logic [7:0] val);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 8)) @(negedge clk) cmd_if.valid <= 1'b0;
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		cmd_if.valid       <= 1'b1;
		cmd_if.opcode      <= op;
		cmd_if.reg_address <= addr;
		cmd_if.write_value <= val;
		do @(posedge clk); while (!cmd_if.ready);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		cmd_if.valid <= 1'b0;
		while (sb.reports_due() != 0) @(negedge clk);
	endtask

	task automatic send_random_word();
		int unsigned pick;
		int unsigned sub;
		logic [7:0]  addr;
		logic [7:0]  val;
		pick = $urandom_range(0, 99);
		sub  = $urandom_range(0, 9);
		addr = 8'($urandom());
		val  = 8'($urandom());
		if (pick < 50) begin
			send_word(rmpsc_pkg::OpTick, addr, val);
		end else if (pick < 54) begin
			if (sub < 7) begin
				val = 8'($urandom_range(0, 2));
			end else if (sub < 9) begin
				val = 8'($urandom_range(3, 12));
			end
			send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRate, val);
		end else if (pick < 72) begin
			if (sub < 5) begin
				val = 8'($urandom_range(0, 200) - 100);
			end else if (sub < 7) begin
				case ($urandom_range(0, 3))
					0: val = 8'd100;
					1: val = 8'd101;
					2: val = -8'sd100;
					default: val = -8'sd101;
				endcase
			end
			send_word(rmpsc_pkg::OpWrite,
				$urandom_range(0, 1) ? rmpsc_pkg::AddrTorpedo : rmpsc_pkg::AddrClaw, val);
		end else if (pick < 90) begin
			send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRed + 8'($urandom_range(0, 2)), val);
		end else begin
			send_word(rmpsc_pkg::OpWrite, addr, val);
		end
	endtask

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		sb                 = new();
		arst_n             = 1'b0;
		cmd_if.valid       = 1'b0;
		cmd_if.opcode      = rmpsc_pkg::OpWrite;
		cmd_if.reg_address = 8'd0;
		cmd_if.write_value = 8'd0;
		rsp_if.ready       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_word(rmpsc_pkg::OpTick, 8'hFF, 8'hFF);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRate, 8'd0);
		send_word(rmpsc_pkg::OpTick, 8'h00, 8'h00);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrClaw, 8'd100);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrClaw, 8'd101);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrTorpedo, -8'sd100);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrTorpedo, -8'sd101);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrClaw, 8'h80);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrTorpedo, 8'h7F);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrTorpedo, 8'h00);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRed, 8'hFF);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrGreen, 8'h00);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrBlue, 8'h01);
		send_word(rmpsc_pkg::OpWrite, 8'h00, 8'hAA);
		send_word(rmpsc_pkg::OpWrite, 8'hFF, 8'h55);
		send_word(rmpsc_pkg::OpTick, 8'hA5, 8'h5A);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRate, 8'd1);
		repeat (4) send_word(rmpsc_pkg::OpTick, 8'h00, 8'hFF);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRate, 8'd255);
		repeat (2) send_word(rmpsc_pkg::OpTick, 8'hFF, 8'h00);
		send_word(rmpsc_pkg::OpWrite, rmpsc_pkg::AddrRate, 8'd0);
		wait_drained();

		for (int i = 0; i < 900; i++) begin
			if (i == 450) begin
				wait_drained();
			end
			send_random_word();
		end
		wait_drained();
		repeat (4) @(posedge clk);

		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/rmpsc_pkg.sv
rtl/rmpsc_cmd_if.sv
rtl/rmpsc_rsp_if.sv
rtl/rmpsc_regs.sv
rtl/rmpsc_slew.sv
rtl/register_mapped_pwm_slew_controller.sv
sim/register_mapped_pwm_slew_controller_tb.sv
